/* rtl/netpbm_stream_decoder_core_assert.svh */
// assertion macros used by the netpbm stream decoder parser rtl
`ifndef NETPBM_STREAM_DECODER_CORE_ASSERT_SVH
`define NETPBM_STREAM_DECODER_CORE_ASSERT_SVH

// checked property, off while reset is held
`define NSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked property, also evaluated across reset
`define NSD_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/nsd_pkg.sv */
// types, codes and helper functions of the netpbm stream decoder
package nsd_pkg;

    localparam int NSD_MAX_WIDTH  = 4096;
    localparam int NSD_MAX_HEIGHT = 4096;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [7:0] {
        PH_MAGIC_P = 8'b0000_0001,
        PH_MAGIC_N = 8'b0000_0010,
        PH_SEP     = 8'b0000_0100,
        PH_WIDTH   = 8'b0000_1000,
        PH_HEIGHT  = 8'b0001_0000,
        PH_MAXVAL  = 8'b0010_0000,
        PH_PLAIN   = 8'b0100_0000,
        PH_RAW     = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        MODE_BIT    = 3'd0,
        MODE_GREY8  = 3'd1,
        MODE_GREY16 = 3'd2,
        MODE_RGB8   = 3'd3,
        MODE_RGB16  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_MAGIC     = 4'd1,
        ERR_SPACE     = 4'd2,
        ERR_ZERO_DIM  = 4'd3,
        ERR_MAXVAL    = 4'd4,
        ERR_TEXT      = 4'd5,
        ERR_OVER_MAX  = 4'd6,
        ERR_SHORT     = 4'd7,
        ERR_DIM_LARGE = 4'd8
    } err_t;

    // format codes from the magic digit
    localparam logic [2:0] FMT_PLAIN_BIT  = 3'd1;
    localparam logic [2:0] FMT_PLAIN_GREY = 3'd2;
    localparam logic [2:0] FMT_PLAIN_RGB  = 3'd3;
    localparam logic [2:0] FMT_RAW_BIT    = 3'd4;
    localparam logic [2:0] FMT_RAW_GREY   = 3'd5;
    localparam logic [2:0] FMT_RAW_RGB    = 3'd6;

    typedef struct packed {
        logic        vld;
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] img_w;
        logic [12:0] img_h;
        logic        eoi;
        err_t        err;
        logic        last;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    // 16-bit sample to 8 bits by div257, saturated
    function automatic logic [7:0] reduce16(input logic [15:0] v);
        logic [16:0] sum;
        sum = {1'b0, v} + {9'd0, v[15:8]};
        return (sum[16:8] > 9'd255) ? 8'hFF : sum[15:8];
    endfunction

endpackage

/* rtl/nsd_parser.sv */
// byte parser: header state machine, sample assembly and pixel counters
`include "netpbm_stream_decoder_core_assert.svh"

module nsd_parser #(
    parameter int MAX_WIDTH  = nsd_pkg::NSD_MAX_WIDTH,
    parameter int MAX_HEIGHT = nsd_pkg::NSD_MAX_HEIGHT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic [7:0]    data_byte,
    input  logic          eos,
    output nsd_pkg::res_t res,
    output logic          consume
);
    import nsd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    phase_t        phase_reg, phase_next;
    logic [2:0]    fmt_reg, fmt_next;
    mode_t         mode_reg, mode_next;
    logic [CW-1:0] width_reg, width_next;
    logic [RW-1:0] height_reg, height_next;
    logic [15:0]   maxval_reg, maxval_next;
    logic [16:0]   acc_reg, acc_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [2:0]    comp_reg, comp_next;
    logic [15:0]   held_reg [3];
    logic [15:0]   held_next [3];
    logic          comment_reg, comment_next;
    logic          err_reg, err_next;
    logic [2:0]    bit_idx_reg, bit_idx_next;

    // digit accumulation, value kept plus one, saturated
    logic [16:0] acc_prev;
    logic [20:0] acc_prod;
    logic [16:0] acc_dig;
    assign acc_prev = (acc_reg == 17'd0) ? 17'd0 : acc_reg - 17'd1;
    assign acc_prod = (21'(acc_prev) * 21'd10) + {17'd0, data_byte[3:0]};
    assign acc_dig  = ((acc_prod > 21'd65536) ? 17'd65536 : acc_prod[16:0]) + 17'd1;

    // raw bitmap byte finishes the image within its eight bits
    logic bm_ends;
    assign bm_ends = (({4'd0, col_reg} + (CW+4)'(8)) >= {4'd0, width_reg}) &&
                     (({1'b0, row_reg} + (RW+1)'(1)) >= {1'b0, height_reg});

    logic          err_go, pv_go, pix_go, bm_go, begin_go, eoi;
    err_t          err_code;
    logic [16:0]   pv_val, fv;
    logic [7:0]    pix_r, pix_g, pix_b, bm_s;
    logic [2:0]    ci;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [31:0]   w32, h32;

    assign w32 = 32'(width_next);
    assign h32 = 32'(height_next);

    // next-state and result logic for one byte or one bitmap bit
    always_comb begin
        phase_next   = phase_reg;
        fmt_next     = fmt_reg;
        mode_next    = mode_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        maxval_next  = maxval_reg;
        acc_next     = acc_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        comp_next    = comp_reg;
        held_next    = held_reg;
        comment_next = comment_reg;
        err_next     = err_reg;
        bit_idx_next = bit_idx_reg;
        res          = '0;
        consume      = step_en;
        err_go       = 1'b0;
        err_code     = ERR_NONE;
        pv_go        = 1'b0;
        pv_val       = '0;
        pix_go       = 1'b0;
        pix_r        = '0;
        pix_g        = '0;
        pix_b        = '0;
        bm_go        = 1'b0;
        bm_s         = '0;
        begin_go     = 1'b0;
        eoi          = 1'b0;
        fv           = acc_reg - 17'd1;
        ci           = '0;
        col_inc      = '0;
        row_inc      = '0;

        if (step_en && !err_reg) begin
            if (comment_reg) begin
                if (data_byte == CH_LF) comment_next = 1'b0;
            end else begin
                case (phase_reg)
                    PH_MAGIC_P: begin
                        if (data_byte == CH_P) phase_next = PH_MAGIC_N;
                        else if (!is_space(data_byte)) begin
                            err_go = 1'b1; err_code = ERR_MAGIC;
                        end
                    end
                    PH_MAGIC_N: begin
                        if (data_byte inside {[CH_1:CH_6]}) begin
                            fmt_next   = data_byte[2:0];
                            phase_next = PH_SEP;
                        end else begin
                            err_go = 1'b1; err_code = ERR_MAGIC;
                        end
                    end
                    PH_SEP: begin
                        if (is_space(data_byte)) begin
                            phase_next = PH_WIDTH;
                            acc_next   = '0;
                        end else begin
                            err_go = 1'b1; err_code = ERR_SPACE;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        if (is_digit(data_byte)) begin
                            acc_next = acc_dig;
                        end else if (is_space(data_byte)) begin
                            if (acc_reg != 17'd0) begin
                                acc_next = '0;
                                if (phase_reg == PH_WIDTH) begin
                                    if (fv == 17'd0) begin
                                        err_go = 1'b1; err_code = ERR_ZERO_DIM;
                                    end else if (fv > 17'(MAX_WIDTH)) begin
                                        err_go = 1'b1; err_code = ERR_DIM_LARGE;
                                    end else begin
                                        width_next = CW'(fv);
                                        phase_next = PH_HEIGHT;
                                    end
                                end else if (phase_reg == PH_HEIGHT) begin
                                    if (fv == 17'd0) begin
                                        err_go = 1'b1; err_code = ERR_ZERO_DIM;
                                    end else if (fv > 17'(MAX_HEIGHT)) begin
                                        err_go = 1'b1; err_code = ERR_DIM_LARGE;
                                    end else begin
                                        height_next = RW'(fv);
                                        if (fmt_reg == FMT_PLAIN_BIT ||
                                            fmt_reg == FMT_RAW_BIT) begin
                                            maxval_next = 16'd1;
                                            mode_next   = MODE_BIT;
                                            begin_go    = 1'b1;
                                        end else begin
                                            phase_next = PH_MAXVAL;
                                        end
                                    end
                                end else begin
                                    if (fv == 17'd0 || fv > 17'd65535) begin
                                        err_go = 1'b1; err_code = ERR_MAXVAL;
                                    end else begin
                                        maxval_next = fv[15:0];
                                        if (fmt_reg == FMT_PLAIN_GREY ||
                                            fmt_reg == FMT_RAW_GREY)
                                            mode_next = (fv > 17'd255) ? MODE_GREY16
                                                                       : MODE_GREY8;
                                        else
                                            mode_next = (fv > 17'd255) ? MODE_RGB16
                                                                       : MODE_RGB8;
                                        begin_go = 1'b1;
                                    end
                                end
                            end
                        end else if (data_byte == CH_HASH && fmt_reg <= FMT_PLAIN_RGB &&
                                     acc_reg == 17'd0) begin
                            comment_next = 1'b1;
                        end else if (acc_reg <= 17'd1) begin
                            err_go   = 1'b1;
                            err_code = (phase_reg == PH_MAXVAL) ? ERR_MAXVAL
                                                                : ERR_ZERO_DIM;
                        end else begin
                            err_go = 1'b1; err_code = ERR_SPACE;
                        end
                    end
                    PH_PLAIN: begin
                        if (is_digit(data_byte)) begin
                            acc_next = acc_dig;
                            if (eos) begin
                                pv_go    = 1'b1;
                                pv_val   = acc_dig - 17'd1;
                                acc_next = '0;
                            end
                        end else if (is_space(data_byte) || data_byte == CH_HASH) begin
                            if (acc_reg != 17'd0) begin
                                pv_go    = 1'b1;
                                pv_val   = fv;
                                acc_next = '0;
                            end
                            if (data_byte == CH_HASH) comment_next = 1'b1;
                        end else begin
                            err_go = 1'b1; err_code = ERR_TEXT;
                        end
                    end
                    PH_RAW: begin
                        ci = (comp_reg > 3'd5) ? 3'd0 : comp_reg;
                        comp_next = ci;
                        case (mode_reg)
                            MODE_BIT: begin
                                if (bit_idx_reg == 3'd0 && eos && !bm_ends) begin
                                    err_go = 1'b1; err_code = ERR_SHORT;
                                end else begin
                                    bm_go  = 1'b1;
                                    bm_s   = data_byte[3'd7 - bit_idx_reg] ? 8'hFF : 8'h00;
                                    pix_go = 1'b1;
                                    pix_r  = bm_s; pix_g = bm_s; pix_b = bm_s;
                                end
                            end
                            MODE_GREY16: begin
                                if (ci == 3'd0) begin
                                    held_next[0] = {data_byte, 8'h00};
                                    comp_next    = 3'd1;
                                end else begin
                                    comp_next = 3'd0;
                                    pix_go    = 1'b1;
                                    pix_r     = reduce16(held_reg[0] | {8'h00, data_byte});
                                    pix_g     = pix_r; pix_b = pix_r;
                                end
                            end
                            MODE_RGB8: begin
                                if (ci > 3'd2) ci = 3'd0;
                                held_next[ci[1:0]] = {8'h00, data_byte};
                                comp_next = ci + 3'd1;
                                if (comp_next >= 3'd3) begin
                                    comp_next = 3'd0;
                                    pix_go    = 1'b1;
                                    pix_r     = held_next[0][7:0];
                                    pix_g     = held_next[1][7:0];
                                    pix_b     = held_next[2][7:0];
                                end
                            end
                            MODE_RGB16: begin
                                if (ci[0])
                                    held_next[ci[2:1]] = held_reg[ci[2:1]] |
                                                         {8'h00, data_byte};
                                else
                                    held_next[ci[2:1]] = {data_byte, 8'h00};
                                comp_next = ci + 3'd1;
                                if (comp_next >= 3'd6) begin
                                    comp_next = 3'd0;
                                    pix_go    = 1'b1;
                                    pix_r     = reduce16(held_next[0]);
                                    pix_g     = reduce16(held_next[1]);
                                    pix_b     = reduce16(held_next[2]);
                                end
                            end
                            default: begin
                                pix_go = 1'b1;
                                pix_r  = data_byte; pix_g = data_byte; pix_b = data_byte;
                            end
                        endcase
                    end
                    default: begin
                        phase_next = PH_MAGIC_P;
                        err_go = 1'b1; err_code = ERR_MAGIC;
                    end
                endcase
            end

            // plain sample value against maxval
            if (pv_go) begin
                if (pv_val > {1'b0, maxval_reg}) begin
                    err_go = 1'b1; err_code = ERR_OVER_MAX;
                end else begin
                    case (mode_reg)
                        MODE_BIT: begin
                            pix_go = 1'b1;
                            pix_r  = (pv_val != 17'd0) ? 8'hFF : 8'h00;
                            pix_g  = pix_r; pix_b = pix_r;
                        end
                        MODE_GREY16: begin
                            pix_go = 1'b1;
                            pix_r  = reduce16(pv_val[15:0]);
                            pix_g  = pix_r; pix_b = pix_r;
                        end
                        MODE_RGB8, MODE_RGB16: begin
                            ci = (comp_reg > 3'd2) ? 3'd0 : comp_reg;
                            held_next[ci[1:0]] = pv_val[15:0];
                            comp_next = ci + 3'd1;
                            if (comp_next >= 3'd3) begin
                                comp_next = 3'd0;
                                pix_go    = 1'b1;
                                if (mode_reg == MODE_RGB8) begin
                                    pix_r = held_next[0][7:0];
                                    pix_g = held_next[1][7:0];
                                    pix_b = held_next[2][7:0];
                                end else begin
                                    pix_r = reduce16(held_next[0]);
                                    pix_g = reduce16(held_next[1]);
                                    pix_b = reduce16(held_next[2]);
                                end
                            end
                        end
                        default: begin
                            pix_go = 1'b1;
                            pix_r  = pv_val[7:0]; pix_g = pix_r; pix_b = pix_r;
                        end
                    endcase
                end
            end

            // pixel counters and end of image
            if (pix_go && !err_go) begin
                col_inc = {1'b0, col_reg} + (CW+1)'(1);
                col_next = col_inc[CW-1:0];
                if (col_inc >= {1'b0, width_reg}) begin
                    col_next = '0;
                    row_inc  = {1'b0, row_reg} + (RW+1)'(1);
                    row_next = row_inc[RW-1:0];
                    if (row_inc >= {1'b0, height_reg}) begin
                        eoi        = 1'b1;
                        row_next   = '0;
                        comp_next  = '0;
                        phase_next = PH_MAGIC_P;
                    end
                end
                res.vld   = 1'b1;
                res.kind  = KIND_PIXEL;
                res.red   = pix_r;
                res.green = pix_g;
                res.blue  = pix_b;
                res.eoi   = eoi;
                res.last  = 1'b1;
            end

            // bitmap byte walks one bit per cycle while step_en is high, until the row or byte ends
            if (bm_go) begin
                if (col_next == '0 || bit_idx_reg == 3'd7) begin
                    bit_idx_next = 3'd0;
                end else begin
                    bit_idx_next = bit_idx_reg + 3'd1;
                    consume      = 1'b0;
                    res.last     = 1'b0;
                end
            end

            // header transfer and start of pixel data
            if (begin_go && !err_go) begin
                col_next   = '0;
                row_next   = '0;
                comp_next  = '0;
                acc_next   = '0;
                held_next[0] = '0; held_next[1] = '0; held_next[2] = '0;
                phase_next = (fmt_reg > FMT_PLAIN_RGB) ? PH_RAW : PH_PLAIN;
                res        = '0;
                res.vld    = 1'b1;
                res.kind   = KIND_HEADER;
                res.img_w  = w32[12:0];
                res.img_h  = h32[12:0];
                res.last   = 1'b1;
            end

            // file ends inside a header or an image
            if (!bm_go && !err_go && eos && phase_next != PH_MAGIC_P) begin
                err_go = 1'b1; err_code = ERR_SHORT;
            end

            if (err_go) begin
                err_next = 1'b1;
                res      = '0;
                res.vld  = 1'b1;
                res.kind = KIND_ERROR;
                res.err  = err_code;
                res.last = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC_P;
            fmt_reg     <= '0;
            mode_reg    <= MODE_BIT;
            width_reg   <= '0;
            height_reg  <= '0;
            maxval_reg  <= '0;
            acc_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            comp_reg    <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
            held_reg[2] <= '0;
            comment_reg <= 1'b0;
            err_reg     <= 1'b0;
            bit_idx_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            fmt_reg     <= fmt_next;
            mode_reg    <= mode_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            maxval_reg  <= maxval_next;
            acc_reg     <= acc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            comp_reg    <= comp_next;
            held_reg    <= held_next;
            comment_reg <= comment_next;
            err_reg     <= err_next;
            bit_idx_reg <= bit_idx_next;
        end
    end

    `NSD_ASSERT(a_err_sticky, err_reg |=> err_reg, "error flag cleared without reset")
    `NSD_ASSERT(a_silent_after_err, (err_reg && step_en) |-> !res.vld, "result after error")
    `NSD_ASSERT(a_bit_walk_raw, (bit_idx_reg != 3'd0) |-> (phase_reg == PH_RAW && mode_reg == MODE_BIT), "bit walk outside raw bitmap")
    `NSD_ASSERT_NORST(a_reset_state, !aresetn |=> (phase_reg == PH_MAGIC_P && !err_reg), "reset state wrong")

endmodule

/* rtl/netpbm_stream_decoder_core.sv */
// netpbm stream decoder top level: input register, parser, result register
//
// Input channel s_: one file byte per transfer, s_end_of_stream on the last
// byte of the file. Result channel m_: one result per transfer, header,
// pixel or error, with m_last_of_run on the last result of each byte.
// A byte sits in the input register and is parsed combinationally straight
// into the result register, so the first result of a byte passes the input
// register and then the result register. Most bytes give at most one result;
// a raw bitmap byte gives one pixel per cycle while m_ready allows, up to eight
// pixels, as the bit walk of the parser emits them into the single result register.
// A byte is taken while the previous result still waits in the result
// register. When the receiver holds m_ready low, the result register holds
// and the parser stops; the input register then fills and s_ready drops.
// Synchronous reset clears the valid flags of both registers and all parser
// state; after an error no further results appear until reset.
module netpbm_stream_decoder_core #(
    parameter int MAX_WIDTH  = nsd_pkg::NSD_MAX_WIDTH,
    parameter int MAX_HEIGHT = nsd_pkg::NSD_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_pixel_red,
    output logic [7:0]  m_pixel_green,
    output logic [7:0]  m_pixel_blue,
    output logic [12:0] m_image_width,
    output logic [12:0] m_image_height,
    output logic        m_end_of_image,
    output logic [3:0]  m_error_code,
    output logic        m_last_of_run
);
    import nsd_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       out_vld_reg;
    res_t       out_res_reg;
    res_t       res;
    logic       consume, advance, step_en;

    assign advance = !out_vld_reg || m_ready;
    assign step_en = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || (step_en && consume);

    nsd_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .eos       (in_eos_reg),
        .res       (res),
        .consume   (consume)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_stream;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= step_en && res.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result_kind  = out_res_reg.kind;
    assign m_pixel_red    = out_res_reg.red;
    assign m_pixel_green  = out_res_reg.green;
    assign m_pixel_blue   = out_res_reg.blue;
    assign m_image_width  = out_res_reg.img_w;
    assign m_image_height = out_res_reg.img_h;
    assign m_end_of_image = out_res_reg.eoi;
    assign m_error_code   = out_res_reg.err;
    assign m_last_of_run  = out_res_reg.last;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the netpbm stream decoder: directed rows, random images, final error
module tb_top;
    import nsd_pkg::*;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] img_w;
        logic [12:0] img_h;
        logic        eoi;
        err_t        err;
        logic        last;
    } dec_res_t;

    typedef struct {
        string txt;
        bit    eos;
        int    n_last;
        err_t  err_last;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_pixel_red;
    logic [7:0]  m_pixel_green;
    logic [7:0]  m_pixel_blue;
    logic [12:0] m_image_width;
    logic [12:0] m_image_height;
    logic        m_end_of_image;
    logic [3:0]  m_error_code;
    logic        m_last_of_run;

    netpbm_stream_decoder_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_pixel_red     (m_pixel_red),
        .m_pixel_green   (m_pixel_green),
        .m_pixel_blue    (m_pixel_blue),
        .m_image_width   (m_image_width),
        .m_image_height  (m_image_height),
        .m_end_of_image  (m_end_of_image),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // decoder shadow state
    phase_t   ph = PH_MAGIC_P;
    int       fmt = 0;
    mode_t    md = MODE_BIT;
    int       wid = 0, hgt = 0, maxv = 0, acc = 0;
    int       col = 0, row = 0, ci = 0;
    int       held [3] = '{0, 0, 0};
    bit       in_cmt = 0, err_lat = 0;

    dec_res_t byte_res[$];
    dec_res_t pending_results[$];
    int       fails = 0;
    int       cycles = 0;
    int       row_chk = -1;
    err_t     row_err = ERR_NONE;
    bit       quiet = 0;
    int       hold = 0;

    function automatic void note_fail(string msg);
        fails++;
        if (fails <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic void add_res(kind_t k, int r, int g, int b, int w, int h, bit eoi,
                                    err_t e);
        dec_res_t x;
        if (byte_res.size() >= 8) return;
        x.kind = k; x.red = r[7:0]; x.green = g[7:0]; x.blue = b[7:0];
        x.img_w = w[12:0]; x.img_h = h[12:0]; x.eoi = eoi; x.err = e; x.last = 1'b0;
        byte_res.push_back(x);
    endfunction

    function automatic void raise_err(err_t e);
        err_lat = 1;
        add_res(KIND_ERROR, 0, 0, 0, 0, 0, 0, e);
    endfunction

    function automatic bit white(int c);
        return c == 32 || (c >= 9 && c <= 13);
    endfunction

    function automatic int div257(int v);
        int t;
        t = (v + (v >> 8)) >> 8;
        return t > 255 ? 255 : t;
    endfunction

    function automatic void put_pix(int r, int g, int b);
        bit eoi;
        eoi = 0;
        col++;
        if (col >= wid) begin
            col = 0;
            row++;
            if (row >= hgt) begin
                eoi = 1; row = 0; ci = 0; ph = PH_MAGIC_P;
            end
        end
        add_res(KIND_PIXEL, r, g, b, 0, 0, eoi, ERR_NONE);
    endfunction

    function automatic void begin_data();
        col = 0; row = 0; ci = 0; acc = 0;
        held = '{0, 0, 0};
        add_res(KIND_HEADER, 0, 0, 0, wid, hgt, 0, ERR_NONE);
        ph = (fmt > FMT_PLAIN_RGB) ? PH_RAW : PH_PLAIN;
    endfunction

    function automatic void add_digit(int d);
        int v;
        v = (acc != 0 ? acc - 1 : 0) * 10 + d;
        if (v > 65536) v = 65536;
        acc = v + 1;
    endfunction

    function automatic void finish_field();
        int v;
        v = acc - 1;
        acc = 0;
        if (ph == PH_WIDTH) begin
            if (v == 0) raise_err(ERR_ZERO_DIM);
            else if (v > NSD_MAX_WIDTH) raise_err(ERR_DIM_LARGE);
            else begin
                wid = v; ph = PH_HEIGHT;
            end
        end else if (ph == PH_HEIGHT) begin
            if (v == 0) raise_err(ERR_ZERO_DIM);
            else if (v > NSD_MAX_HEIGHT) raise_err(ERR_DIM_LARGE);
            else begin
                hgt = v;
                if (fmt == FMT_PLAIN_BIT || fmt == FMT_RAW_BIT) begin
                    maxv = 1; md = MODE_BIT; begin_data();
                end else begin
                    ph = PH_MAXVAL;
                end
            end
        end else begin
            if (v == 0 || v > 65535) raise_err(ERR_MAXVAL);
            else begin
                maxv = v;
                if (fmt == FMT_PLAIN_GREY || fmt == FMT_RAW_GREY)
                    md = v > 255 ? MODE_GREY16 : MODE_GREY8;
                else md = v > 255 ? MODE_RGB16 : MODE_RGB8;
                begin_data();
            end
        end
    endfunction

    function automatic void header_byte(int c);
        if (c >= CH_0 && c <= CH_9) add_digit(c - CH_0);
        else if (white(c)) begin
            if (acc != 0) finish_field();
        end else if (c == CH_HASH && fmt <= FMT_PLAIN_RGB && acc == 0) in_cmt = 1;
        else if (acc <= 1) raise_err(ph == PH_MAXVAL ? ERR_MAXVAL : ERR_ZERO_DIM);
        else raise_err(ERR_SPACE);
    endfunction

    function automatic void plain_value(int v);
        int s;
        if (v > maxv) begin
            raise_err(ERR_OVER_MAX);
            return;
        end
        case (md)
            MODE_BIT: begin
                s = v != 0 ? 255 : 0; put_pix(s, s, s);
            end
            MODE_GREY16: begin
                s = div257(v); put_pix(s, s, s);
            end
            MODE_RGB8, MODE_RGB16: begin
                if (ci > 2) ci = 0;
                held[ci] = v & 16'hFFFF;
                ci++;
                if (ci >= 3) begin
                    ci = 0;
                    if (md == MODE_RGB8) put_pix(held[0], held[1], held[2]);
                    else put_pix(div257(held[0]), div257(held[1]), div257(held[2]));
                end
            end
            default: put_pix(v, v, v);
        endcase
    endfunction

    function automatic void plain_byte(int c, bit eos);
        int v;
        if (c >= CH_0 && c <= CH_9) begin
            add_digit(c - CH_0);
            if (eos) begin
                v = acc - 1; acc = 0; plain_value(v);
            end
        end else if (white(c) || c == CH_HASH) begin
            if (acc != 0) begin
                v = acc - 1; acc = 0; plain_value(v);
            end
            if (c == CH_HASH && !err_lat) in_cmt = 1;
        end else begin
            raise_err(ERR_TEXT);
        end
    endfunction

    function automatic void raw_byte(int c);
        int s, idx;
        if (ci > 5) ci = 0;
        case (md)
            MODE_BIT: begin
                for (int k = 0; k < 8; k++) begin
                    s = (c & (8'h80 >> k)) != 0 ? 255 : 0;
                    put_pix(s, s, s);
                    if (col == 0) break;
                end
            end
            MODE_GREY16: begin
                if (ci == 0) begin
                    held[0] = c << 8; ci = 1;
                end else begin
                    ci = 0; s = div257(held[0] | c); put_pix(s, s, s);
                end
            end
            MODE_RGB8: begin
                if (ci > 2) ci = 0;
                held[ci] = c;
                ci++;
                if (ci >= 3) begin
                    ci = 0; put_pix(held[0], held[1], held[2]);
                end
            end
            MODE_RGB16: begin
                idx = ci >> 1;
                if (ci & 1) held[idx] = held[idx] | c;
                else held[idx] = c << 8;
                ci++;
                if (ci >= 6) begin
                    ci = 0;
                    put_pix(div257(held[0]), div257(held[1]), div257(held[2]));
                end
            end
            default: put_pix(c, c, c);
        endcase
    endfunction

    // results that one accepted byte should produce, left in byte_res
    function automatic void decode_byte(int c, bit eos);
        byte_res.delete();
        if (err_lat) return;
        if (in_cmt) begin
            if (c == CH_LF) in_cmt = 0;
        end else begin
            case (ph)
                PH_MAGIC_P: begin
                    if (c == CH_P) ph = PH_MAGIC_N;
                    else if (!white(c)) raise_err(ERR_MAGIC);
                end
                PH_MAGIC_N: begin
                    if (c >= CH_1 && c <= CH_6) begin
                        fmt = c - CH_0; ph = PH_SEP;
                    end else raise_err(ERR_MAGIC);
                end
                PH_SEP: begin
                    if (white(c)) begin
                        ph = PH_WIDTH; acc = 0;
                    end else raise_err(ERR_SPACE);
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: header_byte(c);
                PH_PLAIN: plain_byte(c, eos);
                default: raw_byte(c);
            endcase
        end
        // short file drops everything else from this byte
        if (!err_lat && eos && ph != PH_MAGIC_P) begin
            byte_res.delete();
            raise_err(ERR_SHORT);
        end
        if (byte_res.size() > 0) byte_res[byte_res.size() - 1].last = 1'b1;
    endfunction

    // watchdog, result check and prediction at each rising edge
    always @(posedge aclk) begin
        dec_res_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                got.kind = kind_t'(m_result_kind);
                got.red = m_pixel_red; got.green = m_pixel_green; got.blue = m_pixel_blue;
                got.img_w = m_image_width; got.img_h = m_image_height;
                got.eoi = m_end_of_image; got.err = err_t'(m_error_code);
                got.last = m_last_of_run;
                if (pending_results.size() == 0) begin
                    note_fail($sformatf("unexpected result %p", got));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_fail($sformatf("expected %p got %p", want, got));
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(int'(s_data_byte), s_end_of_stream);
                if (row_chk >= 0 && byte_res.size() != row_chk)
                    note_fail($sformatf("byte %h: %0d results predicted, row says %0d",
                                        s_data_byte, byte_res.size(), row_chk));
                if (row_chk > 0 && byte_res.size() > 0 && byte_res[0].err != row_err)
                    note_fail($sformatf("byte %h: error %0d predicted, row says %0d",
                                        s_data_byte, byte_res[0].err, row_err));
                foreach (byte_res[i]) pending_results.push_back(byte_res[i]);
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap();
        end
    end

    // one byte per transfer, random gaps in front
    task automatic send_seq(byte_t q[$], bit eos_last, int n_last, err_t e_last);
        int n;
        foreach (q[i]) begin
            n = pick_gap();
            if (n > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_valid <= 1'b1;
            s_data_byte <= q[i];
            s_end_of_stream <= (i == q.size() - 1) ? eos_last : 1'b0;
            row_chk <= (i == q.size() - 1) ? n_last : -1;
            row_err <= e_last;
            do @(posedge aclk); while (!s_ready);
        end
    endtask

    function automatic void str_bytes(ref byte_t q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void put_ws(ref byte_t q[$]);
        int r;
        r = $urandom_range(8, 13);
        q.push_back(r == 8 ? 8'd32 : byte_t'(r));
    endfunction

    // separator, sometimes with a comment, for plain formats
    function automatic void put_sep(ref byte_t q[$], input bit plain);
        byte_t c;
        put_ws(q);
        if (plain && $urandom_range(0, 3) == 0) begin
            q.push_back(CH_HASH);
            repeat ($urandom_range(0, 3)) begin
                c = byte_t'($urandom_range(0, 255));
                q.push_back(c == CH_LF ? CH_HASH : c);
            end
            q.push_back(CH_LF);
            if ($urandom_range(0, 1)) put_ws(q);
        end
    endfunction

    // random well-formed image of any format
    function automatic void build_image(ref byte_t q[$], output bit eos_last);
        int f, w, h, mv, comps, total;
        bit plain, bitmap;
        f = $urandom_range(FMT_PLAIN_BIT, FMT_RAW_RGB);
        plain = f <= FMT_PLAIN_RGB;
        bitmap = f == FMT_PLAIN_BIT || f == FMT_RAW_BIT;
        comps = (f == FMT_PLAIN_RGB || f == FMT_RAW_RGB) ? 3 : 1;
        w = $urandom_range(1, 4);
        if (bitmap && $urandom_range(0, 3) == 0) w = $urandom_range(9, 17);
        h = $urandom_range(1, 3);
        eos_last = 0;
        q.push_back(CH_P);
        q.push_back(byte_t'(CH_0 + f));
        put_sep(q, plain);
        str_bytes(q, $sformatf("%0d", w));
        put_sep(q, plain);
        str_bytes(q, $sformatf("%0d", h));
        mv = 1;
        if (!bitmap) begin
            case ($urandom_range(0, 3))
                0: mv = 255;
                1: mv = 65535;
                2: mv = $urandom_range(1, 254);
                default: mv = $urandom_range(256, 65535);
            endcase
            put_sep(q, plain);
            str_bytes(q, $sformatf("%0d", mv));
        end
        if (plain) put_sep(q, 1);
        else put_ws(q);
        if (plain) begin
            total = w * h * comps;
            for (int i = 0; i < total; i++) begin
                if ($urandom_range(0, 7) == 0) str_bytes(q, $sformatf("%0d", mv));
                else str_bytes(q, $sformatf("%0d", $urandom_range(0, mv)));
                if (i < total - 1) put_sep(q, 1);
                else if ($urandom_range(0, 4) == 0) eos_last = 1;
                else put_ws(q);
            end
        end else begin
            total = bitmap ? ((w + 7) / 8) * h : w * h * comps * (mv > 255 ? 2 : 1);
            repeat (total) q.push_back(byte_t'($urandom_range(0, 255)));
            eos_last = $urandom_range(0, 4) == 0;
        end
    endfunction

    stim_row_t directed_rows [] = '{
        '{" \t\r\n\013\014", 0, 0, ERR_NONE},
        '{"P1\n2 1\n0 1\n", 0, 1, ERR_NONE},
        '{"P2 # note\n1 1 65535 65535 ", 0, 1, ERR_NONE},
        '{"P2\t2 1\t255\t#c\n0 255\n", 0, 1, ERR_NONE},
        '{"P3 1 1 255 0 255 12\n", 0, 1, ERR_NONE},
        '{"P3 1 1 65535 65535 0 257 ", 0, 1, ERR_NONE},
        '{"P4 9 1 \377", 0, 8, ERR_NONE},
        '{"\200", 0, 1, ERR_NONE},
        '{"P4 8 2 ", 0, 1, ERR_NONE},
        '{"\125", 0, 8, ERR_NONE},
        '{"\252", 0, 8, ERR_NONE},
        '{"P5 2 1 255 \001\377", 0, 1, ERR_NONE},
        '{"P5 1 1 65535 \377\377", 0, 1, ERR_NONE},
        '{"P6 1 1 255 \001\002\003", 0, 1, ERR_NONE},
        '{"P6 1 1 300 \377\377\001\001\200\200", 0, 1, ERR_NONE},
        '{"P1 1 1 1", 1, 1, ERR_NONE}
    };

    // one of these closes the run, since errors stick until reset
    stim_row_t error_rows [] = '{
        '{"P7", 0, 1, ERR_MAGIC},
        '{"P6 1a", 0, 1, ERR_SPACE},
        '{"P2 1 0 ", 0, 1, ERR_ZERO_DIM},
        '{"P2 3 1 0 ", 0, 1, ERR_MAXVAL},
        '{"P3 1 1 255 9 x", 0, 1, ERR_TEXT},
        '{"P1 1 1 2 ", 0, 1, ERR_OVER_MAX},
        '{"P2 2 1 255 7", 1, 1, ERR_SHORT},
        '{"P5 4097 ", 0, 1, ERR_DIM_LARGE}
    };

    initial begin
        byte_t q[$];
        bit    eos_last;
        int    sent, img;
        stim_row_t er;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        foreach (directed_rows[i]) begin
            q.delete();
            str_bytes(q, directed_rows[i].txt);
            send_seq(q, directed_rows[i].eos, directed_rows[i].n_last,
                     directed_rows[i].err_last);
        end

        // random images
        sent = 0;
        img = 0;
        while (sent < 100) begin
            q.delete();
            build_image(q, eos_last);
            quiet = $urandom_range(0, 3) == 0;
            if (img == 3) begin
                // hold off until the output side has drained
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            send_seq(q, eos_last, -1, ERR_NONE);
            sent += q.size();
            img++;
        end
        quiet = 0;

        // closing error, then bytes that must yield nothing
        er = error_rows[$urandom_range(0, error_rows.size() - 1)];
        q.delete();
        str_bytes(q, er.txt);
        send_seq(q, er.eos, er.n_last, er.err_last);
        q.delete();
        str_bytes(q, "P1 1 1 1 ");
        send_seq(q, 0, 0, ERR_NONE);
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
